// ===== rtl/bwng_pkg.sv =====
// bwng_pkg: types and constants for the butterworth notch gain unit
// no dependencies
`default_nettype none
package bwng_pkg;

  localparam int MAG_W  = 32;
  localparam int COL_W  = 12;
  localparam int DIM_W  = 13;
  localparam int OFF_W  = 12;
  localparam int CR_W   = 16;
  localparam int ORD_W  = 4;
  localparam int N_W    = 5;
  localparam int GAIN_W = 17;
  localparam int MANT_W = 32;
  localparam int EXP_W  = 12;
  localparam int DEN_W  = 33;
  localparam int DIFF_LIMIT = 40;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
  localparam logic [GAIN_W-1:0] GAIN_ZERO = 17'h00000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER        = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
    logic signed [OFF_W-1:0] notch_col_offset;
    logic signed [OFF_W-1:0] notch_row_offset;
    logic [CR_W-1:0]         cutoff_radius;
    logic [ORD_W-1:0]        filter_order;
  } cfg_t;

  // travels alongside the gain computation
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic              bypass;
    logic              force_en;
    logic [GAIN_W-1:0] force_gain;
  } side_t;

  typedef struct packed {
    logic [MANT_W-1:0]       ma;
    logic [MANT_W-1:0]       mb;
    logic [MANT_W-1:0]       pa;
    logic [MANT_W-1:0]       pb;
    logic signed [EXP_W-1:0] ea;
    logic signed [EXP_W-1:0] eb;
    logic signed [EXP_W-1:0] xa;
    logic signed [EXP_W-1:0] xb;
    logic [N_W-1:0]          n;
  } pwr_t;

endpackage
`default_nettype wire

// ===== rtl/bwng_if.sv =====
// bwng_in_if and bwng_out_if: valid/ready channels of the notch gain unit
// depends on bwng_pkg
`default_nettype none
interface bwng_in_if;
  logic                          valid;
  logic                          ready;
  logic [bwng_pkg::MAG_W-1:0]    magnitude_in;
  logic [bwng_pkg::COL_W-1:0]    pixel_col;
  logic [bwng_pkg::COL_W-1:0]    pixel_row;
  modport source (output valid, magnitude_in, pixel_col, pixel_row, input ready);
  modport sink   (input valid, magnitude_in, pixel_col, pixel_row, output ready);
endinterface

interface bwng_out_if;
  logic                       valid;
  logic                       ready;
  logic [bwng_pkg::MAG_W-1:0] magnitude_out;
  modport source (output valid, magnitude_out, input ready);
  modport sink   (input valid, magnitude_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/bwng_front.sv =====
// bwng_front: offsets, squared distance and mantissa normalisation, four stages
// depends on bwng_pkg
`default_nettype none
module bwng_front #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_ORDER = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [bwng_pkg::MAG_W-1:0]  in_mag,
  input  wire logic [bwng_pkg::COL_W-1:0]  in_col,
  input  wire logic [bwng_pkg::COL_W-1:0]  in_row,
  input  wire bwng_pkg::cfg_t              cfg,
  output logic                             out_valid,
  output bwng_pkg::side_t                  out_side,
  output bwng_pkg::pwr_t                   out_pwr
);

  typedef struct packed {
    logic [bwng_pkg::MANT_W-1:0]       m;
    logic signed [bwng_pkg::EXP_W-1:0] e;
  } norm_t;

  function automatic norm_t normalise(input logic [35:0] v);
    norm_t r;
    int k;
    logic [63:0] wide;
    k = 0;
    for (int i = 0; i < 36; i++) begin
      if (v[i]) k = i;
    end
    if (k > 31) begin
      wide = 64'(v) >> (k - 31);
    end else begin
      wide = 64'(v) << (31 - k);
    end
    r.m = wide[31:0];
    r.e = bwng_pkg::EXP_W'(k - 31);
    return r;
  endfunction

  // stage 0: offsets
  logic                               v0_r;
  bwng_pkg::side_t                    sd0_r;
  logic signed [14:0]                 dx0_r, dy0_r;
  logic [bwng_pkg::N_W-1:0]           n0_r;
  logic                               crz0_r;
  logic [bwng_pkg::CR_W-1:0]          cr0_r;

  logic [bwng_pkg::DIM_W-1:0] w_c, h_c;
  logic [11:0]                hw, hh;
  logic                       bypass_nxt;
  logic [bwng_pkg::N_W-1:0]   n_nxt;

  always_comb begin
    w_c = (32'(cfg.image_width) > 32'(MAX_DIM)) ? bwng_pkg::DIM_W'(MAX_DIM)
                                                : cfg.image_width;
    h_c = (32'(cfg.image_height) > 32'(MAX_DIM)) ? bwng_pkg::DIM_W'(MAX_DIM)
                                                 : cfg.image_height;
    hw = w_c[12:1];
    hh = h_c[12:1];
    bypass_nxt = ({1'b0, in_col} >= {hw, 1'b0}) || ({1'b0, in_row} >= {hh, 1'b0});
    if (cfg.filter_order == '0) begin
      n_nxt = bwng_pkg::N_W'(1);
    end else if (32'(cfg.filter_order) > 32'(MAX_ORDER)) begin
      n_nxt = bwng_pkg::N_W'(MAX_ORDER);
    end else begin
      n_nxt = bwng_pkg::N_W'(cfg.filter_order);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
    if (en) begin
      sd0_r.mag        <= in_mag;
      sd0_r.bypass     <= bypass_nxt;
      sd0_r.force_en   <= 1'b0;
      sd0_r.force_gain <= bwng_pkg::GAIN_ZERO;
      dx0_r  <= $signed({3'b000, in_col}) - $signed({3'b000, hw})
                - 15'(cfg.notch_col_offset);
      dy0_r  <= $signed({3'b000, in_row}) - $signed({3'b000, hh})
                - 15'(cfg.notch_row_offset);
      n0_r   <= n_nxt;
      crz0_r <= (cfg.cutoff_radius == '0);
      cr0_r  <= cfg.cutoff_radius;
    end
  end

  // stage 1: squares
  logic                      v1_r;
  bwng_pkg::side_t           sd1_r;
  logic [26:0]               sx1_r, sy1_r;
  logic [31:0]               b1_r;
  logic [bwng_pkg::N_W-1:0]  n1_r;
  logic                      crz1_r;
  logic signed [29:0]        sqx, sqy;

  always_comb begin
    sqx = dx0_r * dx0_r;
    sqy = dy0_r * dy0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
    if (en) begin
      sd1_r  <= sd0_r;
      sx1_r  <= sqx[26:0];
      sy1_r  <= sqy[26:0];
      b1_r   <= 32'(cr0_r) * 32'(cr0_r);
      n1_r   <= n0_r;
      crz1_r <= crz0_r;
    end
  end

  // stage 2: distance and special gains
  logic                      v2_r;
  bwng_pkg::side_t           sd2_r;
  logic [35:0]               a2_r;
  logic [31:0]               b2_r;
  logic [bwng_pkg::N_W-1:0]  n2_r;
  logic [27:0]               d2;

  assign d2 = {1'b0, sx1_r} + {1'b0, sy1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      sd2_r.mag    <= sd1_r.mag;
      sd2_r.bypass <= sd1_r.bypass;
      if (d2 == '0) begin
        sd2_r.force_en   <= 1'b1;
        sd2_r.force_gain <= bwng_pkg::GAIN_ZERO;
      end else if (crz1_r) begin
        sd2_r.force_en   <= 1'b1;
        sd2_r.force_gain <= bwng_pkg::GAIN_ONE;
      end else begin
        sd2_r.force_en   <= 1'b0;
        sd2_r.force_gain <= bwng_pkg::GAIN_ZERO;
      end
      a2_r <= {d2, 8'h00};
      b2_r <= b1_r;
      n2_r <= n1_r;
    end
  end

  // stage 3: normalise
  logic            v3_r;
  bwng_pkg::side_t sd3_r;
  bwng_pkg::pwr_t  pw3_r;
  norm_t           na, nb;

  always_comb begin
    na = normalise(a2_r);
    nb = normalise({4'h0, b2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      sd3_r    <= sd2_r;
      pw3_r.ma <= na.m;
      pw3_r.pa <= na.m;
      pw3_r.ea <= na.e;
      pw3_r.xa <= na.e;
      pw3_r.mb <= nb.m;
      pw3_r.pb <= nb.m;
      pw3_r.eb <= nb.e;
      pw3_r.xb <= nb.e;
      pw3_r.n  <= n2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_side  = sd3_r;
  assign out_pwr   = pw3_r;

endmodule
`default_nettype wire

// ===== rtl/bwng_power.sv =====
// bwng_power: one mantissa multiply stage per order step for cutoff and distance
// depends on bwng_pkg
`default_nettype none
module bwng_power #(
  parameter int MAX_ORDER = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire bwng_pkg::side_t in_side,
  input  wire bwng_pkg::pwr_t  in_pwr,
  output logic                 out_valid,
  output bwng_pkg::side_t      out_side,
  output bwng_pkg::pwr_t       out_pwr
);

  function automatic bwng_pkg::pwr_t step(input bwng_pkg::pwr_t p);
    bwng_pkg::pwr_t r;
    logic [63:0] prod_a, prod_b;
    r = p;
    prod_a = 64'(p.pa) * 64'(p.ma);
    prod_b = 64'(p.pb) * 64'(p.mb);
    if (prod_a[63]) begin
      r.pa = prod_a[63:32];
      r.xa = p.xa + p.ea + bwng_pkg::EXP_W'(32);
    end else begin
      r.pa = prod_a[62:31];
      r.xa = p.xa + p.ea + bwng_pkg::EXP_W'(31);
    end
    if (prod_b[63]) begin
      r.pb = prod_b[63:32];
      r.xb = p.xb + p.eb + bwng_pkg::EXP_W'(32);
    end else begin
      r.pb = prod_b[62:31];
      r.xb = p.xb + p.eb + bwng_pkg::EXP_W'(31);
    end
    return r;
  endfunction

  logic            v   [MAX_ORDER];
  bwng_pkg::side_t sd  [MAX_ORDER];
  bwng_pkg::pwr_t  pw  [MAX_ORDER];

  assign v[0]  = in_valid;
  assign sd[0] = in_side;
  assign pw[0] = in_pwr;

  for (genvar i = 1; i < MAX_ORDER; i++) begin : g_stage
    logic            v_r;
    bwng_pkg::side_t sd_r;
    bwng_pkg::pwr_t  pw_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v[i-1];
      end
      if (en) begin
        sd_r <= sd[i-1];
        pw_r <= (bwng_pkg::N_W'(i) < pw[i-1].n) ? step(pw[i-1]) : pw[i-1];
      end
    end
    assign v[i]  = v_r;
    assign sd[i] = sd_r;
    assign pw[i] = pw_r;
  end

  assign out_valid = v[MAX_ORDER-1];
  assign out_side  = sd[MAX_ORDER-1];
  assign out_pwr   = pw[MAX_ORDER-1];

endmodule
`default_nettype wire

// ===== rtl/bwng_divider.sv =====
// bwng_divider: exponent alignment and a restoring divider, one quotient bit a stage
// depends on bwng_pkg
`default_nettype none
module bwng_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire bwng_pkg::side_t              in_side,
  input  wire bwng_pkg::pwr_t               in_pwr,
  output logic                              out_valid,
  output bwng_pkg::side_t                   out_side,
  output logic [bwng_pkg::GAIN_W-1:0]       out_quot
);

  localparam int QB = bwng_pkg::GAIN_W;

  typedef struct packed {
    logic [bwng_pkg::DEN_W-1:0] rem;
    logic [bwng_pkg::DEN_W-1:0] den;
    logic [QB-1:0]              low;
    logic [QB-1:0]              quot;
  } div_t;

  // alignment stage
  logic signed [bwng_pkg::EXP_W:0] diff;
  logic [bwng_pkg::MANT_W-1:0]     na, nb;
  logic [bwng_pkg::DEN_W-1:0]      den;
  logic [48:0]                     dividend;
  bwng_pkg::side_t                 sd_nxt;

  always_comb begin
    diff = (bwng_pkg::EXP_W+1)'(in_pwr.xa) - (bwng_pkg::EXP_W+1)'(in_pwr.xb);
    na = in_pwr.pa;
    nb = in_pwr.pb;
    if (diff > 0) begin
      nb = in_pwr.pb >> diff[5:0];
    end else if (diff < 0) begin
      na = in_pwr.pa >> 6'(-diff);
    end
    den = {1'b0, na} + {1'b0, nb};
    dividend = {1'b0, na, 16'h0000} + 49'(den >> 1);
    sd_nxt = in_side;
    if (!in_side.force_en) begin
      if (diff >= bwng_pkg::DIFF_LIMIT) begin
        sd_nxt.force_en   = 1'b1;
        sd_nxt.force_gain = bwng_pkg::GAIN_ONE;
      end else if (diff <= -bwng_pkg::DIFF_LIMIT) begin
        sd_nxt.force_en   = 1'b1;
        sd_nxt.force_gain = bwng_pkg::GAIN_ZERO;
      end
    end
  end

  logic            v  [QB+1];
  bwng_pkg::side_t sd [QB+1];
  div_t            dv [QB+1];

  logic            v0_r;
  bwng_pkg::side_t sd0_r;
  div_t            dv0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
    if (en) begin
      sd0_r      <= sd_nxt;
      dv0_r.rem  <= {1'b0, dividend[48:QB]};
      dv0_r.den  <= den;
      dv0_r.low  <= dividend[QB-1:0];
      dv0_r.quot <= '0;
    end
  end

  assign v[0]  = v0_r;
  assign sd[0] = sd0_r;
  assign dv[0] = dv0_r;

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic                         v_r;
    bwng_pkg::side_t              sd_r;
    div_t                         dv_r;
    logic [bwng_pkg::DEN_W:0]     t;
    div_t                         nx;
    always_comb begin
      t = {dv[i-1].rem, dv[i-1].low[QB-1]};
      nx = dv[i-1];
      nx.low = {dv[i-1].low[QB-2:0], 1'b0};
      if (t >= {1'b0, dv[i-1].den}) begin
        nx.rem  = bwng_pkg::DEN_W'(t - {1'b0, dv[i-1].den});
        nx.quot = {dv[i-1].quot[QB-2:0], 1'b1};
      end else begin
        nx.rem  = t[bwng_pkg::DEN_W-1:0];
        nx.quot = {dv[i-1].quot[QB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v[i-1];
      end
      if (en) begin
        sd_r <= sd[i-1];
        dv_r <= nx;
      end
    end
    assign v[i]  = v_r;
    assign sd[i] = sd_r;
    assign dv[i] = dv_r;
  end

  assign out_valid = v[QB];
  assign out_side  = sd[QB];
  assign out_quot  = dv[QB].quot;

endmodule
`default_nettype wire

// ===== rtl/butterworth_notch_gain_unit.sv =====
// butterworth_notch_gain_unit: front end, order multiply chain, 17 stage divider and gain
// multiply; one word per cycle while the output word is not waiting.
// the whole pipeline advances together and holds while the output word waits.
// synchronous active-low reset clears valid bits and loads the register defaults.
// depends on bwng_pkg, bwng_if, bwng_front, bwng_power, bwng_divider
`default_nettype none
module butterworth_notch_gain_unit #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_ORDER = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  bwng_in_if.sink                                  in_s,
  bwng_out_if.source                               out_s,
  input  wire logic                                cfg_we,
  input  wire logic [bwng_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bwng_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bwng_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= 13'd512;
      cfg_r.image_height     <= 13'd512;
      cfg_r.notch_col_offset <= '0;
      cfg_r.notch_row_offset <= '0;
      cfg_r.cutoff_radius    <= 16'd480;
      cfg_r.filter_order     <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bwng_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width      <= cfg_data[12:0];
        bwng_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height     <= cfg_data[12:0];
        bwng_pkg::REG_NOTCH_COL:    cfg_r.notch_col_offset <= cfg_data[11:0];
        bwng_pkg::REG_NOTCH_ROW:    cfg_r.notch_row_offset <= cfg_data[11:0];
        bwng_pkg::REG_CUTOFF:       cfg_r.cutoff_radius    <= cfg_data;
        bwng_pkg::REG_ORDER:        cfg_r.filter_order     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  logic [bwng_pkg::MAG_W-1:0] out_mag_r;

  assign en = !out_valid_r || out_s.ready;
  assign in_s.ready = en;

  logic            f_valid;
  bwng_pkg::side_t f_side;
  bwng_pkg::pwr_t  f_pwr;

  bwng_front #(.MAX_DIM(MAX_DIM), .MAX_ORDER(MAX_ORDER)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_s.valid),
    .in_mag    (in_s.magnitude_in),
    .in_col    (in_s.pixel_col),
    .in_row    (in_s.pixel_row),
    .cfg       (cfg_r),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_pwr   (f_pwr)
  );

  logic            p_valid;
  bwng_pkg::side_t p_side;
  bwng_pkg::pwr_t  p_pwr;

  bwng_power #(.MAX_ORDER(MAX_ORDER)) u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_pwr    (f_pwr),
    .out_valid (p_valid),
    .out_side  (p_side),
    .out_pwr   (p_pwr)
  );

  logic                          d_valid;
  bwng_pkg::side_t               d_side;
  logic [bwng_pkg::GAIN_W-1:0]   d_quot;

  bwng_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .in_side   (p_side),
    .in_pwr    (p_pwr),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quot  (d_quot)
  );

  // gain multiply
  logic                          m_valid_r;
  logic                          m_bypass_r;
  logic [bwng_pkg::MAG_W-1:0]    m_mag_r;
  logic [48:0]                   m_prod_r;
  logic [bwng_pkg::GAIN_W-1:0]   gain;

  assign gain = d_side.force_en ? d_side.force_gain : d_quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= d_valid;
    end
    if (en) begin
      m_bypass_r <= d_side.bypass;
      m_mag_r    <= d_side.mag;
      m_prod_r   <= 49'(d_side.mag) * 49'(gain);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_valid_r;
    end
    if (en) begin
      out_mag_r <= m_bypass_r ? m_mag_r : m_prod_r[47:16];
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.magnitude_out = out_mag_r;

endmodule
`default_nettype wire

// ===== rtl/bwng_checker.sv =====
// bwng_checker: port-level assertions for the notch gain unit, bound to the top level
// depends on butterworth_notch_gain_unit
`default_nettype none
module bwng_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_word
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("output word changed while stalled");

endmodule

bind butterworth_notch_gain_unit bwng_checker u_bwng_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_word  (out_s.magnitude_out)
);
`default_nettype wire

// ===== sim/butterworth_notch_gain_unit_checker.sv =====
// butterworth_notch_gain_unit_checker: watches the register port and both channels,
// predicts each filtered magnitude and compares it with the word the unit returns
// depends on bwng_pkg and the bwng_in_if / bwng_out_if interfaces
module butterworth_notch_gain_unit_checker #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_ORDER = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bwng_in_if                               in_m,
  bwng_out_if                              out_m,
  input  logic                             cfg_we,
  input  logic [bwng_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bwng_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [bwng_pkg::DIM_W-1:0]        width_r;
  logic [bwng_pkg::DIM_W-1:0]        height_r;
  logic signed [bwng_pkg::OFF_W-1:0] col_off_r;
  logic signed [bwng_pkg::OFF_W-1:0] row_off_r;
  logic [bwng_pkg::CR_W-1:0]         cutoff_r;
  logic [bwng_pkg::ORD_W-1:0]        order_r;
  logic [bwng_pkg::MAG_W-1:0]        filtered_q[$];

  function automatic void normalise(input longint unsigned v, output longint unsigned m,
                                    output int e);
    int k;
    k = 0;
    while (k < 63 && (v >> (k + 1)) != 0) k++;
    if (k > 31) begin
      m = v >> (k - 31);
      e = k - 31;
    end else begin
      m = v << (31 - k);
      e = -(31 - k);
    end
  endfunction

  function automatic void raise(input longint unsigned m, input int e, input int n,
                                output longint unsigned pm, output int pe);
    longint unsigned p;
    longint unsigned prod;
    int x;
    p = m;
    x = e;
    for (int i = 1; i < n; i++) begin
      prod = p * m;
      x += e;
      if (prod[63]) begin
        p = prod >> 32;
        x += 32;
      end else begin
        p = prod >> 31;
        x += 31;
      end
    end
    pm = p;
    pe = x;
  endfunction

  function automatic longint unsigned notch_gain(input longint unsigned d2,
                                                 input longint unsigned cr, input int n);
    longint unsigned ma, mb, pa, pb, den;
    int ea, eb, xa, xb, diff;
    if (d2 == 0) return 0;
    if (cr == 0) return 65536;
    normalise(d2 << 8, ma, ea);
    normalise(cr * cr, mb, eb);
    raise(ma, ea, n, pa, xa);
    raise(mb, eb, n, pb, xb);
    diff = xa - xb;
    if (diff >= bwng_pkg::DIFF_LIMIT) return 65536;
    if (diff <= -bwng_pkg::DIFF_LIMIT) return 0;
    if (diff > 0) pb = pb >> diff;
    else if (diff < 0) pa = pa >> (-diff);
    den = pa + pb;
    return (pa * 65536 + den / 2) / den;
  endfunction

  function automatic logic [bwng_pkg::MAG_W-1:0] filtered_mag(
      input logic [bwng_pkg::MAG_W-1:0] mag,
      input logic [bwng_pkg::COL_W-1:0] col,
      input logic [bwng_pkg::COL_W-1:0] row);
    longint w, h, hw, hh, dx, dy;
    longint unsigned g, prod;
    int n;
    w = (width_r > MAX_DIM) ? MAX_DIM : width_r;
    h = (height_r > MAX_DIM) ? MAX_DIM : height_r;
    hw = w / 2;
    hh = h / 2;
    n = order_r;
    if (n == 0) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    if (longint'(col) >= 2 * hw || longint'(row) >= 2 * hh) return mag;
    dx = longint'(col) - hw - longint'(col_off_r);
    dy = longint'(row) - hh - longint'(row_off_r);
    g = notch_gain(longint'(dx * dx + dy * dy), cutoff_r, n);
    prod = longint'(mag) * g;
    return prod[47:16];
  endfunction

  assign pending = filtered_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 13'd512;
      height_r   <= 13'd512;
      col_off_r  <= '0;
      row_off_r  <= '0;
      cutoff_r   <= 16'd480;
      order_r    <= 4'd2;
      fail_count <= 0;
      checked    <= 0;
      filtered_q.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bwng_pkg::REG_IMAGE_WIDTH:  width_r   <= cfg_data[bwng_pkg::DIM_W-1:0];
          bwng_pkg::REG_IMAGE_HEIGHT: height_r  <= cfg_data[bwng_pkg::DIM_W-1:0];
          bwng_pkg::REG_NOTCH_COL:    col_off_r <= cfg_data[bwng_pkg::OFF_W-1:0];
          bwng_pkg::REG_NOTCH_ROW:    row_off_r <= cfg_data[bwng_pkg::OFF_W-1:0];
          bwng_pkg::REG_CUTOFF:       cutoff_r  <= cfg_data[bwng_pkg::CR_W-1:0];
          bwng_pkg::REG_ORDER:        order_r   <= cfg_data[bwng_pkg::ORD_W-1:0];
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready)
        filtered_q.push_back(filtered_mag(in_m.magnitude_in, in_m.pixel_col, in_m.pixel_row));
      if (out_m.valid && out_m.ready) begin
        checked <= checked + 1;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, out_m.magnitude_out);
          fail_count <= fail_count + 1;
        end else if (filtered_q[0] !== out_m.magnitude_out) begin
          $display("%0t: magnitude_out expected %h actual %h", $time, filtered_q[0],
                   out_m.magnitude_out);
          fail_count <= fail_count + 1;
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
    end
  end
endmodule

// ===== sim/butterworth_notch_gain_unit_tb.sv =====
// butterworth_notch_gain_unit_tb: drives magnitude samples through register phases
// with varied idling and gives the verdict from the checker's failure count
// depends on bwng_pkg, bwng_if, the unit and butterworth_notch_gain_unit_checker
module butterworth_notch_gain_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int N_PHASES    = 12;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [bwng_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bwng_pkg::CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, checked;
  int idle_pct, stall_pct, words_sent, quiet_cycles;
  int cur_w, cur_h;

  bwng_in_if  in_if();
  bwng_out_if out_if();

  butterworth_notch_gain_unit dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_if), .out_s(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  butterworth_notch_gain_unit_checker chk (
    .clk(clk), .rst_n(rst_n), .in_m(in_if), .out_m(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always #1 clk = ~clk;

  always @(negedge clk) out_if.ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(input logic [bwng_pkg::MAG_W-1:0] mag,
                           input logic [bwng_pkg::COL_W-1:0] col,
                           input logic [bwng_pkg::COL_W-1:0] row);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.magnitude_in = mag;
    in_if.pixel_col    = col;
    in_if.pixel_row    = row;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bwng_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bwng_pkg::CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_word();
    logic [bwng_pkg::MAG_W-1:0] mag;
    logic [bwng_pkg::COL_W-1:0] col, row;
    int wl, hl;
    wl = (cur_w > 4096) ? 4096 : cur_w;
    hl = (cur_h > 4096) ? 4096 : cur_h;
    case ($urandom_range(9))
      0: mag = 32'hffff_ffff;
      1: mag = $urandom_range(255);
      default: mag = $urandom;
    endcase
    if ($urandom_range(9) == 0) begin
      col = $urandom;
      row = $urandom;
    end else begin
      col = $urandom_range(wl > 4095 ? 4095 : wl);
      row = $urandom_range(hl > 4095 ? 4095 : hl);
    end
    send_word(mag, col, row);
  endtask

  initial begin
    static logic [bwng_pkg::CFG_DATA_W-1:0] ph_w[N_PHASES] = '{512, 2, 4096, 8191, 3, 1, 0,
                                                  64, 4095, 100, 640, 257};
    static logic [bwng_pkg::CFG_DATA_W-1:0] ph_h[N_PHASES] = '{512, 2, 4096, 4096, 5, 64, 64,
                                                  1, 4095, 0, 480, 8191};
    static logic [bwng_pkg::CFG_DATA_W-1:0] ph_co[N_PHASES] = '{0, 0, 16'hf800, 2047, 1, 0,
                                                  0, 5, 16'hffe0, 3, 100, 16'hffff};
    static logic [bwng_pkg::CFG_DATA_W-1:0] ph_ro[N_PHASES] = '{0, 16'hffff, 16'hf800, 2047,
                                                  0, 2, 0, 0, 30, 16'hff9c, 16'hffec,
                                                  16'hf800};
    static logic [bwng_pkg::CFG_DATA_W-1:0] ph_cr[N_PHASES] = '{480, 1, 65535, 0, 16, 320,
                                                  1000, 65535, 40000, 0, 2000, 5};
    static logic [bwng_pkg::CFG_DATA_W-1:0] ph_ord[N_PHASES] = '{2, 1, 8, 0, 15, 3, 4, 8, 5,
                                                  1, 6, 7};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bwng_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.magnitude_in = '0;
    in_if.pixel_col = '0;
    in_if.pixel_row = '0;
    out_if.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    words_sent = 0;
    quiet_cycles = 0;
    cur_w = 512;
    cur_h = 512;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: centre, corners, bypass column and row, near cutoff
    send_word(32'hffff_ffff, 12'd256, 12'd256);
    send_word(32'h0000_0000, 12'd0, 12'd0);
    send_word(32'hffff_ffff, 12'd0, 12'd0);
    send_word(32'hffff_ffff, 12'd511, 12'd511);
    send_word(32'h1234_5678, 12'd512, 12'd10);
    send_word(32'h8765_4321, 12'd10, 12'd512);
    send_word(32'hffff_ffff, 12'd4095, 12'd4095);
    send_word(32'hffff_ffff, 12'd286, 12'd256);
    send_word(32'h0000_0100, 12'd257, 12'd256);
    send_word(32'haaaa_5555, 12'hfff, 12'h000);
    send_word(32'h5555_aaaa, 12'd256, 12'd226);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(bwng_pkg::REG_IMAGE_WIDTH, ph_w[p]);
      write_reg(bwng_pkg::REG_IMAGE_HEIGHT, ph_h[p]);
      write_reg(bwng_pkg::REG_NOTCH_COL, ph_co[p]);
      write_reg(bwng_pkg::REG_NOTCH_ROW, ph_ro[p]);
      write_reg(bwng_pkg::REG_CUTOFF, ph_cr[p]);
      write_reg(bwng_pkg::REG_ORDER, ph_ord[p]);
      cur_w = ph_w[p] & 16'h1fff;
      cur_h = ph_h[p] & 16'h1fff;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      repeat (120) random_word();
      drain();
    end

    $display("run covered %0d words over %0d register phases, %0d results compared",
             words_sent, N_PHASES + 1, checked);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
